FILE: design/assert_macros.svh
// Assertion macros shared by the blacklist table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZCBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZCBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/zcbt_pkg.sv
// Types and constants for the zoned card blacklist table.
`timescale 1ns / 1ps
`default_nettype none
package zcbt_pkg;

    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_SAVE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [2:0] ST_NOT_LISTED = 3'd0;
    localparam logic [2:0] ST_LISTED     = 3'd1;
    localparam logic [2:0] ST_ADDED      = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_READ       = 3'd4;

    // card / 1000000 = (card >> 6) / 15625, by reciprocal multiply
    localparam int unsigned CARD_SHIFT = 6;
    localparam logic [26:0] ZONE_MUL   = 27'd70368745;
    localparam int unsigned ZONE_SHR   = 40;
    // q / 10 for q < 8192
    localparam logic [12:0] DIG_MUL    = 13'd6554;
    localparam int unsigned DIG_SHR    = 16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] card_number;
        logic [3:0]  zone_select;
        logic [9:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] entry_value;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic zq;
        logic zd;
        logic zr;
        logic prep;
        logic scan;
        logic rd_issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic scan_done;
    } t_sts;

endpackage
`default_nettype wire

FILE: design/zcbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module zcbt_ram #(
    parameter int W = 32,
    parameter int D = 1024,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/zcbt_ctrl.sv
// Sequencer for the blacklist table: zone math, search, read and finish steps.
`timescale 1ns / 1ps
`default_nettype none
module zcbt_ctrl import zcbt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output logic      o_busy,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZQ,
        S_ZD,
        S_ZR,
        S_PREP,
        S_SCAN,
        S_RD,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_ZQ;
                        r_busy  <= 1'b1;
                    end
                end
                S_ZQ:   r_state <= S_ZD;
                S_ZD:   r_state <= S_ZR;
                S_ZR:   r_state <= S_PREP;
                S_PREP: r_state <= i_sts.is_read ? S_RD : S_SCAN;
                S_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_RD:   r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.zq       = (r_state == S_ZQ);
        o_cmd.zd       = (r_state == S_ZD);
        o_cmd.zr       = (r_state == S_ZR);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.rd_issue = (r_state == S_RD);
        o_cmd.finish   = (r_state == S_FIN);
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

FILE: design/zcbt_dp.sv
// Datapath: zone digit, zone counts, entry store, linear search and result register.
`timescale 1ns / 1ps
`default_nettype none
module zcbt_dp import zcbt_pkg::*; #(
    parameter int ZONES            = 10,
    parameter int ENTRIES_PER_ZONE = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_in_item i_item,
    output t_sts          o_sts,
    output logic          o_valid,
    output t_out_item     o_result
);

    localparam int DEPTH = ZONES * ENTRIES_PER_ZONE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(ENTRIES_PER_ZONE + 1);
    localparam int MW    = (AW > CW) ? AW : CW;
    localparam int SW    = ((MW > 10) ? MW : 10) + 1;
    localparam int RW    = (CW > 10) ? CW : 10;

    t_in_item         r_item;
    logic [12:0]      r_q;
    logic [8:0]       r_qd;
    logic [3:0]       r_zone;
    logic [3:0]       r_sel;
    logic             r_ok;
    logic [CW-1:0]    r_used;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_idx;
    logic             r_pend;
    logic             r_hit;
    logic [CW-1:0]    r_counts [ZONES];
    logic             r_valid;
    t_out_item        r_result;

    logic [52:0]      w_prod_zone;
    logic [25:0]      w_prod_dig;
    logic [12:0]      w_digit;
    logic [3:0]       w_sel;
    logic [CW-1:0]    w_used;
    logic             w_issue;
    logic [AW-1:0]    w_scan_addr;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic             w_add;
    logic             w_rd_ok;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [31:0]      w_rdata;
    t_out_item        n_result;

    // zone = (card / 1000000) mod 10, over three registered steps
    assign w_prod_zone = 53'(r_item.card_number[31:CARD_SHIFT]) * 53'(ZONE_MUL);
    assign w_prod_dig  = 26'(r_q) * 26'(DIG_MUL);
    assign w_digit     = r_q - {r_qd, 3'b000} - {3'b000, r_qd, 1'b0};

    assign w_sel = (r_item.mode == MODE_READ) ? r_item.zone_select : r_zone;

    always_comb begin
        w_used = '0;
        for (int z = 0; z < ZONES; z++) begin
            if (w_sel == 4'(z)) begin
                w_used = r_counts[z];
            end
        end
    end

    assign w_issue     = i_cmd.scan && (r_idx < r_used) && !r_hit;
    assign w_scan_addr = AW'(SW'(r_base) + SW'(r_idx));
    assign w_rd_addr   = AW'(SW'(r_base) + SW'(r_item.entry_index));
    assign w_wr_addr   = AW'(SW'(r_base) + SW'(r_used));
    assign w_re        = w_issue || i_cmd.rd_issue;
    assign w_raddr     = i_cmd.rd_issue ? w_rd_addr : w_scan_addr;

    assign w_add   = (r_item.mode == MODE_SAVE) && r_ok && !r_hit
                     && (r_used < CW'(ENTRIES_PER_ZONE));
    assign w_rd_ok = r_ok && (RW'(r_item.entry_index) < RW'(r_used));

    always_comb begin
        n_result.entry_value = '0;
        case (r_item.mode)
            MODE_CHECK: n_result.status = r_hit ? ST_LISTED : ST_NOT_LISTED;
            MODE_SAVE: begin
                if (!r_ok) begin
                    n_result.status = ST_FULL;
                end else if (r_hit) begin
                    n_result.status = ST_LISTED;
                end else if (w_add) begin
                    n_result.status = ST_ADDED;
                end else begin
                    n_result.status = ST_FULL;
                end
            end
            MODE_READ: begin
                n_result.status = ST_READ;
                if (w_rd_ok) begin
                    n_result.entry_value = w_rdata;
                end
            end
            default: n_result.status = ST_NOT_LISTED;
        endcase
    end

    zcbt_ram #(
        .W(32),
        .D(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.finish && w_add),
        .i_waddr(w_wr_addr),
        .i_wdata(r_item.card_number),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.zq) begin
            r_q <= w_prod_zone[52:ZONE_SHR];
        end
        if (i_cmd.zd) begin
            r_qd <= w_prod_dig[DIG_SHR+8:DIG_SHR];
        end
        if (i_cmd.zr) begin
            r_zone <= w_digit[3:0];
        end
        if (i_cmd.prep) begin
            r_sel  <= w_sel;
            r_ok   <= (32'(w_sel) < ZONES);
            r_used <= (32'(w_sel) < ZONES) ? w_used : '0;
            r_base <= AW'(32'(w_sel) * ENTRIES_PER_ZONE);
            r_idx  <= '0;
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend && (w_rdata == r_item.card_number)) begin
                r_hit <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int z = 0; z < ZONES; z++) begin
                r_counts[z] <= '0;
            end
        end else begin
            r_valid <= i_cmd.finish;
            for (int z = 0; z < ZONES; z++) begin
                if (i_cmd.finish && w_add && (r_sel == 4'(z))) begin
                    r_counts[z] <= r_used + 1'b1;
                end
            end
        end
    end

    assign o_sts.is_read   = (r_item.mode == MODE_READ);
    assign o_sts.scan_done = !r_pend && ((r_idx == r_used) || r_hit);
    assign o_valid         = r_valid;
    assign o_result        = r_result;

endmodule
`default_nettype wire

FILE: design/zoned_card_blacklist_table_unit.sv
// Sequence: accept, three zone-math steps and prep, then a single entry read (read mode) or
// a search of the zone's count entries, where count is the zone's fill (up to ENTRIES_PER_ZONE),
// run one entry per cycle through the entry RAM read port; a hit ends it early; then finish.
// Flow: one transaction at a time; start is taken again in the o_valid cycle.
// Reset clears zone counts and control; entry RAM is not cleared (no clearing pass).
// Results show for one cycle on o_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module zoned_card_blacklist_table_unit import zcbt_pkg::*; #(
    parameter int ZONES            = 10,
    parameter int ENTRIES_PER_ZONE = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_item,
    output logic          busy,
    output logic          o_valid,
    output t_out_item     o_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    zcbt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (w_sts),
        .o_busy (busy),
        .o_cmd  (w_cmd)
    );

    zcbt_dp #(
        .ZONES           (ZONES),
        .ENTRIES_PER_ZONE(ENTRIES_PER_ZONE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_item),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    `ZCBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_valid, "accept must raise busy")
    `ZCBT_ASSERT_NOW(a_done_idle, o_valid, !busy, "result while still busy")
    `ZCBT_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `ZCBT_ASSERT_NOW(a_status_range, o_valid, o_result.status <= ST_READ, "status code out of range")

endmodule
`default_nettype wire

FILE: dv/card_table_checker.sv
// Scoreboard for the blacklist table: tracks zone contents and checks every result.
`timescale 1ns / 1ps
module card_table_checker import zcbt_pkg::*; #(
    parameter int ZONES            = 10,
    parameter int ENTRIES_PER_ZONE = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_in_item  i_item,
    input  logic      o_valid,
    input  t_out_item o_result,
    output int        mismatch_count,
    output int        open_requests
);

    localparam logic [31:0] ZONE_DIVISOR = 32'd1_000_000;
    localparam logic [31:0] ZONE_DIGITS  = 32'd10;

    int unsigned zone_fill [ZONES];
    logic [31:0] zone_cards [ZONES][ENTRIES_PER_ZONE];
    t_out_item   answers_due [$];

    initial begin
        mismatch_count = 0;
        open_requests  = 0;
    end

    function automatic bit zone_has_card(int unsigned zone, logic [31:0] card);
        int unsigned used;
        used = zone_fill[zone];
        if (used > ENTRIES_PER_ZONE) used = ENTRIES_PER_ZONE;
        for (int unsigned n = 0; n < used; n++) begin
            if (zone_cards[zone][n] == card) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the answer to one transaction and apply any append it causes.
    function automatic t_out_item apply_card_request(t_in_item req);
        t_out_item   ans;
        int unsigned zone;
        ans  = '0;
        zone = (req.card_number / ZONE_DIVISOR) % ZONE_DIGITS;
        case (req.mode)
            MODE_CHECK: begin
                if (zone < ZONES && zone_has_card(zone, req.card_number))
                    ans.status = ST_LISTED;
                else
                    ans.status = ST_NOT_LISTED;
            end
            MODE_SAVE: begin
                if (zone >= ZONES) begin
                    ans.status = ST_FULL;
                end else if (zone_has_card(zone, req.card_number)) begin
                    ans.status = ST_LISTED;
                end else if (zone_fill[zone] >= ENTRIES_PER_ZONE) begin
                    ans.status = ST_FULL;
                end else begin
                    zone_cards[zone][zone_fill[zone]] = req.card_number;
                    zone_fill[zone]++;
                    ans.status = ST_ADDED;
                end
            end
            MODE_READ: begin
                ans.status = ST_READ;
                if (req.zone_select < ZONES && req.entry_index < zone_fill[req.zone_select]
                        && req.entry_index < ENTRIES_PER_ZONE)
                    ans.entry_value = zone_cards[req.zone_select][req.entry_index];
            end
            default: ans = '0;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            for (int z = 0; z < ZONES; z++) zone_fill[z] = 0;
            answers_due.delete();
        end else begin
            // retire the oldest answer before queuing a new transaction
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result: status %0d, entry_value %h",
                           o_result.status, o_result.entry_value);
                    mismatch_count++;
                end else begin
                    due = answers_due.pop_front();
                    if (o_result.status !== due.status) begin
                        $error("status: expected %0d, actual %0d",
                               due.status, o_result.status);
                        mismatch_count++;
                    end
                    if (o_result.entry_value !== due.entry_value) begin
                        $error("entry_value: expected %h, actual %h",
                               due.entry_value, o_result.entry_value);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) answers_due.push_back(apply_card_request(i_item));
        end
        open_requests <= answers_due.size();
    end

endmodule

FILE: dv/testbench.sv
// Top-level stimulus for the zoned card blacklist table: directed cases, zone fill, random mix.
`timescale 1ns / 1ps
module testbench;
    import zcbt_pkg::*;

    localparam int ZONES            = 10;
    localparam int ENTRIES_PER_ZONE = 1024;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 340;
    localparam int FILL_SAVES   = 200;
    localparam int STALL_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned CARD_MAX = 64'hFFFF_FFFF;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;
    int        mismatch_count;
    int        open_requests;
    int        stall_cycles = 0;
    bit        steady = 1'b0;
    int        full_zone;
    logic [31:0] listed_pool [$];
    logic [31:0] full_pool [$];

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    zoned_card_blacklist_table_unit #(
        .ZONES(ZONES),
        .ENTRIES_PER_ZONE(ENTRIES_PER_ZONE)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_item(i_item),
        .busy(busy),
        .o_valid(o_valid),
        .o_result(o_result)
    );

    card_table_checker #(
        .ZONES(ZONES),
        .ENTRIES_PER_ZONE(ENTRIES_PER_ZONE)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_valid(o_valid),
        .o_result(o_result),
        .mismatch_count(mismatch_count),
        .open_requests(open_requests)
    );

    // Abort when no transaction moves in either direction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_item make_item(logic [1:0] mode, logic [31:0] card,
                                           logic [3:0] zsel, logic [9:0] idx);
        t_in_item req;
        req.mode        = mode;
        req.card_number = card;
        req.zone_select = zsel;
        req.entry_index = idx;
        return req;
    endfunction

    // Random card whose millions digit is the given zone.
    function automatic logic [31:0] card_in_zone(int unsigned digit);
        longint unsigned v;
        do begin
            v = 64'($urandom_range(0, 429)) * 64'd10_000_000 + 64'(digit) * 64'd1_000_000
                + 64'($urandom_range(0, 999_999));
        end while (v > CARD_MAX);
        return v[31:0];
    endfunction

    function automatic int unsigned zone_of(logic [31:0] card);
        return (card / 32'd1_000_000) % 32'd10;
    endfunction

    function automatic logic [31:0] some_card();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && listed_pool.size() != 0)
            return listed_pool[$urandom_range(0, listed_pool.size() - 1)];
        if (r == 4 && full_pool.size() != 0)
            return full_pool[$urandom_range(0, full_pool.size() - 1)];
        return $urandom();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if ($urandom_range(0, 99) < 5) steady = !steady;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send(input t_in_item req);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    initial begin
        t_in_item    req;
        int          made;
        int unsigned sel;
        logic [31:0] card;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes of the card range, every mode
        send(make_item(MODE_READ, 32'h0, 4'd0, 10'd0));
        send(make_item(MODE_CHECK, 32'h0, 4'd0, 10'd0));
        send(make_item(MODE_SAVE, 32'h0, 4'hF, 10'h3FF));
        send(make_item(MODE_CHECK, 32'h0, 4'hF, 10'h3FF));
        send(make_item(MODE_SAVE, 32'h0, 4'd0, 10'd0));
        send(make_item(MODE_SAVE, 32'hFFFF_FFFF, 4'd0, 10'd0));
        send(make_item(MODE_CHECK, 32'hFFFF_FFFF, 4'd0, 10'd0));
        send(make_item(MODE_READ, 32'hFFFF_FFFF, 4'd4, 10'd0));
        send(make_item(MODE_READ, 32'h0, 4'd4, 10'd1));
        send(make_item(MODE_READ, 32'h0, 4'd0, 10'd0));
        send(make_item(MODE_READ, 32'h0, 4'd15, 10'd0));
        send(make_item(MODE_READ, 32'h0, 4'd10, 10'h3FF));
        send(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 4'hF, 10'h3FF));
        send(make_item(MODE_SAVE, 32'd9_999_999, 4'd0, 10'd0));
        send(make_item(MODE_CHECK, 32'd9_999_999, 4'd0, 10'd0));
        send(make_item(MODE_CHECK, 32'd19_999_999, 4'd0, 10'd0));
        send(make_item(MODE_READ, 32'h0, 4'd9, 10'd0));
        send(make_item(MODE_READ, 32'h0, 4'd9, 10'h3FF));
        listed_pool.push_back(32'h0);
        listed_pool.push_back(32'hFFFF_FFFF);
        listed_pool.push_back(32'd9_999_999);

        // load one zone heavily so later searches run long
        full_zone = $urandom_range(0, ZONES - 1);
        for (int n = 0; n < FILL_SAVES; n++) begin
            card = card_in_zone(full_zone);
            full_pool.push_back(card);
            send(make_item(MODE_SAVE, card, 4'($urandom()), 10'($urandom())));
        end
        foreach (listed_pool[i]) begin
            if (zone_of(listed_pool[i]) == full_zone) full_pool.push_back(listed_pool[i]);
        end

        made = 0;
        while (made < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            req = make_item(MODE_CHECK, $urandom(), 4'($urandom()), 10'($urandom()));
            if (sel < 5) begin
                req.mode = MODE_UNUSED;
            end else begin
                made++;
                if (sel < 35) begin
                    req.card_number = some_card();
                end else if (sel < 68) begin
                    req.mode        = MODE_SAVE;
                    req.card_number = some_card();
                    if (zone_of(req.card_number) != full_zone)
                        listed_pool.push_back(req.card_number);
                end else begin
                    req.mode = MODE_READ;
                    if ($urandom_range(0, 4) != 0)
                        req.zone_select = 4'($urandom_range(0, ZONES - 1));
                    else
                        req.zone_select = 4'($urandom_range(ZONES, 15));
                    if ($urandom_range(0, 1) == 0)
                        req.entry_index = 10'($urandom_range(0, 15));
                end
            end
            send(req);
        end
        start <= 1'b0;

        do begin
            @(posedge i_clk);
        end while (open_requests != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && open_requests == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
